### src/ffra_pkg.sv
`timescale 1ns / 1ps
package ffra_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int ADDR_BITS   = 16;
    localparam int IDX_W       = $clog2(MAX_REGIONS);
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [APB_AW-3:0] REG_MEMORY_SIZE = '0;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_DEFRAG = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        C_NOP,
        C_INSERT,
        C_DELETE,
        C_SPLIT,
        C_SETLEN,
        C_SETHEAD,
        C_DEFRAG
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic [IDX_W-1:0]       idx;
        logic [ADDR_BITS-1:0]   a;
        logic [ADDR_BITS:0]     b;
        logic [ADDR_BITS-1:0]   sz;
    } t_cell_cmd;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] len;
    } t_region;

    typedef struct packed {
        logic [ADDR_BITS:0] stop;
        logic               fit;
    } t_view;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_FIRST,
        S_A_SCAN,
        S_A_INS,
        S_F_LO,
        S_F_HI,
        S_F_DEC,
        S_F_HEAD,
        S_F_DEL,
        S_DEFRAG,
        S_DONE
    } t_state;

endpackage

### src/ffra_if.sv
`timescale 1ns / 1ps
interface ffra_cmd_if import ffra_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [ADDR_BITS-1:0] req_offset;
    logic [ADDR_BITS-1:0] req_length;

    modport source (output valid, opcode, req_offset, req_length, input ready);
    modport sink (input valid, opcode, req_offset, req_length, output ready);
endinterface

interface ffra_rsp_if import ffra_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] alloc_address;
    logic [1:0]           status;
    logic [CNT_W-1:0]     regions_used;

    modport source (output valid, alloc_address, status, regions_used, input ready);
    modport sink (input valid, alloc_address, status, regions_used, output ready);
endinterface

### src/ffra_cell.sv
`timescale 1ns / 1ps
module ffra_cell import ffra_pkg::*; (
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_cmd        i_cmd,
    input  logic [CNT_W-1:0] i_count,
    input  t_region          i_left,
    input  t_region          i_right,
    output t_region          o_data,
    output t_view            o_view
);

    t_region              r_data;
    t_region              n_data;
    logic [ADDR_BITS:0]   w_end;
    logic [ADDR_BITS:0]   w_left_end;
    logic [ADDR_BITS+1:0] w_need_end;
    logic                 w_last;
    logic                 w_here;
    logic                 w_after;
    logic                 w_next_to;

    assign w_end      = {1'b0, r_data.start} + {1'b0, r_data.len};
    assign w_left_end = {1'b0, i_left.start} + {1'b0, i_left.len};
    assign w_need_end = {1'b0, w_end} + {1'b0, i_cmd.b};
    assign w_last     = (CNT_W'(i_index) + CNT_W'(1)) == i_count;
    assign w_here     = i_cmd.idx == i_index;
    assign w_after    = i_index > i_cmd.idx;
    assign w_next_to  = CNT_W'(i_index) == (CNT_W'(i_cmd.idx) + CNT_W'(1));

    // gap after this region: to the next start, or to the end of memory when last
    assign o_view.fit  = w_last ? (w_need_end <= {2'b0, i_cmd.sz})
                                : (w_need_end <= {2'b0, i_right.start});
    assign o_view.stop = w_end;
    assign o_data      = r_data;

    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            C_INSERT: begin
                if (w_here) begin
                    n_data.start = i_cmd.a;
                    n_data.len   = i_cmd.b[ADDR_BITS-1:0];
                end else if (w_after) begin
                    n_data = i_left;
                end
            end
            C_DELETE: begin
                if (w_here || w_after) begin
                    n_data = i_right;
                end
            end
            C_SPLIT: begin
                if (w_here) begin
                    n_data.len = i_cmd.a - r_data.start;
                end else if (w_next_to) begin
                    n_data.start = i_cmd.b[ADDR_BITS-1:0];
                    n_data.len   = w_left_end[ADDR_BITS-1:0] - i_cmd.b[ADDR_BITS-1:0];
                end else if (w_after) begin
                    n_data = i_left;
                end
            end
            C_SETLEN: begin
                if (w_here) begin
                    n_data.len = i_cmd.a - r_data.start;
                end
            end
            C_SETHEAD: begin
                if (w_here) begin
                    n_data.start = i_cmd.b[ADDR_BITS-1:0];
                    n_data.len   = w_end[ADDR_BITS-1:0] - i_cmd.b[ADDR_BITS-1:0];
                end
            end
            C_DEFRAG: begin
                if (w_here) begin
                    n_data.start = w_left_end[ADDR_BITS-1:0];
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

### src/first_fit_region_allocator.sv
`timescale 1ns / 1ps
// one transaction at a time; the next is accepted the cycle after the response is registered
// allocate: scan gaps in order from address 0 and insert into the first that fits
// free: scan to the hit regions, trim the kept ends, then delete dropped regions one by one
// defragment: packs each region against the one before; an unused opcode just responds
// synchronous active-low reset empties the table and sets memory_size to 65535
module first_fit_region_allocator import ffra_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ffra_cmd_if.sink            i_cmd,
    ffra_rsp_if.source          o_rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_k, n_k;
    logic [ADDR_BITS-1:0] r_off, n_off;
    logic [ADDR_BITS-1:0] r_need, n_need;
    logic [ADDR_BITS:0]   r_stop, n_stop;
    logic [IDX_W-1:0]     r_lo, n_lo;
    logic [IDX_W-1:0]     r_last, n_last;
    logic [ADDR_BITS-1:0] r_ls, n_ls;
    logic [ADDR_BITS:0]   r_he, n_he;
    logic [IDX_W-1:0]     r_d0, n_d0;
    logic [CNT_W-1:0]     r_n, n_n;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    t_status              r_status, n_status;
    logic [ADDR_BITS-1:0] r_size;
    logic                 r_ov, n_ov;
    logic [ADDR_BITS-1:0] r_oaddr, n_oaddr;
    t_status              r_ostatus, n_ostatus;
    logic [CNT_W-1:0]     r_ocount, n_ocount;

    t_cell_cmd            w_cmd;
    t_region              w_data [MAX_REGIONS];
    t_view                w_view [MAX_REGIONS];
    t_region              w_cur;
    t_view                w_cur_view;
    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_keep_lo;
    logic                 w_keep_hi;
    logic                 w_cfg_wr;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_REGIONS; gi++) begin : g_cell
            t_region w_left;
            t_region w_right;
            if (gi == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid
                assign w_left = w_data[gi-1];
            end
            if (gi == MAX_REGIONS - 1) begin : g_tail
                assign w_right = '0;
            end else begin : g_body
                assign w_right = w_data[gi+1];
            end
            ffra_cell u_cell (
                .i_clk   (i_clk),
                .i_index (IDX_W'(gi)),
                .i_cmd   (w_cmd),
                .i_count (r_count),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[gi]),
                .o_view  (w_view[gi])
            );
        end
    endgenerate

    assign w_cur      = w_data[r_k[IDX_W-1:0]];
    assign w_cur_view = w_view[r_k[IDX_W-1:0]];
    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign w_out_free = !r_ov || o_rsp.ready;
    assign w_keep_lo  = r_off > r_ls;
    assign w_keep_hi  = r_stop < r_he;

    assign i_cmd.ready         = r_state == S_IDLE;
    assign o_rsp.valid         = r_ov;
    assign o_rsp.alloc_address = r_oaddr;
    assign o_rsp.status        = r_ostatus;
    assign o_rsp.regions_used  = r_ocount;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_MEMORY_SIZE);
    assign prdata   = (paddr[APB_AW-1:2] == REG_MEMORY_SIZE) ? APB_DW'(r_size) : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (t_opcode'(i_cmd.opcode))
                        OP_ALLOC:  n_state = S_A_FIRST;
                        OP_FREE:   n_state = S_F_LO;
                        OP_DEFRAG: n_state = S_DEFRAG;
                        OP_NONE:   n_state = S_DONE;
                    endcase
                end
            end
            S_A_FIRST: begin
                if (r_count >= CNT_W'(MAX_REGIONS)) begin
                    n_state = S_DONE;
                end else if (r_count == '0) begin
                    n_state = ({1'b0, r_need} <= {1'b0, r_size}) ? S_A_INS : S_DONE;
                end else if (r_need <= w_data[0].start) begin
                    n_state = S_A_INS;
                end else begin
                    n_state = S_A_SCAN;
                end
            end
            S_A_SCAN: begin
                if (w_cur_view.fit) begin
                    n_state = S_A_INS;
                end else if (r_k == r_count - CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_A_INS: n_state = S_DONE;
            S_F_LO: begin
                if (r_k >= r_count) begin
                    n_state = S_DONE;
                end else if (r_stop <= {1'b0, w_cur.start}) begin
                    n_state = S_DONE;
                end else if (!(w_cur_view.stop <= {1'b0, r_off})) begin
                    n_state = S_F_HI;
                end
            end
            S_F_HI: begin
                if (!(r_k < r_count && r_stop > {1'b0, w_cur.start})) begin
                    n_state = S_F_DEC;
                end
            end
            S_F_DEC: begin
                if (r_last == r_lo && w_keep_lo && w_keep_hi) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_F_HEAD;
                end
            end
            S_F_HEAD: n_state = S_F_DEL;
            S_F_DEL: begin
                if (r_n == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DEFRAG: begin
                if (r_k >= r_count) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and cell commands
    always_comb begin
        w_cmd     = '{op: C_NOP, idx: '0, a: r_off, b: r_stop, sz: r_size};
        n_count   = r_count;
        n_k       = r_k;
        n_off     = r_off;
        n_need    = r_need;
        n_stop    = r_stop;
        n_lo      = r_lo;
        n_last    = r_last;
        n_ls      = r_ls;
        n_he      = r_he;
        n_d0      = r_d0;
        n_n       = r_n;
        n_pos     = r_pos;
        n_addr    = r_addr;
        n_status  = r_status;
        n_ov      = r_ov && !o_rsp.ready;
        n_oaddr   = r_oaddr;
        n_ostatus = r_ostatus;
        n_ocount  = r_ocount;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_off    = i_cmd.req_offset;
                    n_need   = i_cmd.req_length;
                    n_stop   = {1'b0, i_cmd.req_offset} + {1'b0, i_cmd.req_length};
                    n_k      = '0;
                    n_addr   = '0;
                    n_status = ST_OK;
                    n_pos    = '0;
                end
            end
            S_A_FIRST: begin
                if (r_count >= CNT_W'(MAX_REGIONS)) begin
                    n_status = ST_FULL;
                end else if (r_count == '0) begin
                    if (!({1'b0, r_need} <= {1'b0, r_size})) begin
                        n_status = ST_NOFIT;
                    end
                end
            end
            S_A_SCAN: begin
                w_cmd.b = {1'b0, r_need};
                if (w_cur_view.fit) begin
                    n_pos  = IDX_W'(r_k + CNT_W'(1));
                    n_addr = w_cur_view.stop[ADDR_BITS-1:0];
                end else if (r_k == r_count - CNT_W'(1)) begin
                    n_status = ST_NOFIT;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end
            S_A_INS: begin
                w_cmd.op  = C_INSERT;
                w_cmd.idx = r_pos;
                w_cmd.a   = r_addr;
                w_cmd.b   = {1'b0, r_need};
                n_count   = r_count + CNT_W'(1);
            end
            S_F_LO: begin
                if (r_k < r_count && !(r_stop <= {1'b0, w_cur.start})) begin
                    if (w_cur_view.stop <= {1'b0, r_off}) begin
                        n_k = r_k + CNT_W'(1);
                    end else begin
                        n_lo   = r_k[IDX_W-1:0];
                        n_last = r_k[IDX_W-1:0];
                        n_ls   = w_cur.start;
                        n_he   = w_cur_view.stop;
                        n_k    = r_k + CNT_W'(1);
                    end
                end
            end
            S_F_HI: begin
                if (r_k < r_count && r_stop > {1'b0, w_cur.start}) begin
                    n_last = r_k[IDX_W-1:0];
                    n_he   = w_cur_view.stop;
                    n_k    = r_k + CNT_W'(1);
                end
            end
            S_F_DEC: begin
                if (r_last == r_lo && w_keep_lo && w_keep_hi) begin
                    // range strictly inside one region
                    if (r_count >= CNT_W'(MAX_REGIONS)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.op  = C_SPLIT;
                        w_cmd.idx = r_lo;
                        n_count   = r_count + CNT_W'(1);
                    end
                end else begin
                    if (w_keep_lo) begin
                        w_cmd.op  = C_SETLEN;
                        w_cmd.idx = r_lo;
                    end
                    n_d0 = r_lo + IDX_W'(w_keep_lo);
                    n_n  = CNT_W'(r_last) + CNT_W'(!w_keep_hi)
                         - CNT_W'(r_lo) - CNT_W'(w_keep_lo);
                end
            end
            S_F_HEAD: begin
                if (w_keep_hi) begin
                    w_cmd.op  = C_SETHEAD;
                    w_cmd.idx = r_last;
                end
            end
            S_F_DEL: begin
                if (r_n != '0) begin
                    w_cmd.op  = C_DELETE;
                    w_cmd.idx = r_d0;
                    n_count   = r_count - CNT_W'(1);
                    n_n       = r_n - CNT_W'(1);
                end
            end
            S_DEFRAG: begin
                if (r_k < r_count) begin
                    w_cmd.op  = C_DEFRAG;
                    w_cmd.idx = r_k[IDX_W-1:0];
                    n_k       = r_k + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_oaddr   = r_addr;
                    n_ostatus = r_status;
                    n_ocount  = r_count;
                end
            end
            default: begin
                w_cmd.op = C_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_size  <= '1;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (w_cfg_wr) begin
                r_size <= pwdata[ADDR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_off     <= n_off;
        r_need    <= n_need;
        r_stop    <= n_stop;
        r_lo      <= n_lo;
        r_last    <= n_last;
        r_ls      <= n_ls;
        r_he      <= n_he;
        r_d0      <= n_d0;
        r_n       <= n_n;
        r_pos     <= n_pos;
        r_addr    <= n_addr;
        r_status  <= n_status;
        r_oaddr   <= n_oaddr;
        r_ostatus <= n_ostatus;
        r_ocount  <= n_ocount;
    end

endmodule
